[rtl/ema_filter_with_decimated_average_macros.svh]
// Assertion macros for the EMA filter with decimated average.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef EMA_FILTER_WITH_DECIMATED_AVERAGE_MACROS_SVH
`define EMA_FILTER_WITH_DECIMATED_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ema_avg_pkg.sv]
// Shared types and constants for the EMA filter with decimated average.
// No dependencies; used by every module of the block.
`default_nettype none

package ema_avg_pkg;

    localparam int TEMP_W     = 24;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_W      = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPORT_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SMOOTHING_GAIN  = 2'd2;

    localparam logic [CFG_W-1:0] RST_SAMPLE_INTERVAL = 16'd20;
    localparam logic [CFG_W-1:0] RST_REPORT_INTERVAL = 16'd100;
    localparam logic [CFG_W-1:0] RST_SMOOTHING_GAIN  = 16'd9830;

    typedef struct packed {
        logic        [TIME_W-1:0] now_ms;
        logic signed [TEMP_W-1:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] filtered_temp;
        logic                     sample_taken;
        logic                     report_valid;
        logic signed [TEMP_W-1:0] report_average;
    } t_out_item;

    // Classified work passed from the front to the back.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     take_sample;
        logic                     do_report;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/ema_filter_with_decimated_average.sv]
// A sampled item passes from the queue through the MUL1, MUL2, ADD, ACC, REP and OUT states
// to the output register; one that takes no sample goes through REP and OUT only; a report
// adds serial mean division (DIV, FIX). The back end takes no new item until it is back in idle,
// and output stalls hold it in OUT. A two-entry queue decouples the front end.
// Reset (i_rst_n low, synchronous) restores the default intervals and gain, clears the
// time stamps, filter, sum and count, and empties the queue and the output register.
`default_nettype none

module ema_filter_with_decimated_average #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire ema_avg_pkg::t_in_item              i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output ema_avg_pkg::t_out_item                  o_out_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ema_avg_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ema_avg_pkg::APB_W-1:0]      pwdata,
    output logic [ema_avg_pkg::APB_W-1:0]           prdata,
    output logic                                    pready
);

    `include "ema_filter_with_decimated_average_macros.svh"

    logic [ema_avg_pkg::CFG_W-1:0] r_sample_interval;
    logic [ema_avg_pkg::CFG_W-1:0] r_report_interval;
    logic [ema_avg_pkg::CFG_W-1:0] r_gain;
    logic                          w_cfg_write;
    logic [1:0]                    w_reg_idx;
    logic                          w_push;
    logic                          w_pop;
    logic                          w_q_full;
    logic                          w_q_empty;
    ema_avg_pkg::t_cmd             w_front_cmd;
    ema_avg_pkg::t_cmd             w_queue_cmd;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[3:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg_idx)
            ema_avg_pkg::REG_SAMPLE_INTERVAL: prdata = {16'd0, r_sample_interval};
            ema_avg_pkg::REG_REPORT_INTERVAL: prdata = {16'd0, r_report_interval};
            ema_avg_pkg::REG_SMOOTHING_GAIN:  prdata = {16'd0, r_gain};
            default:                          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= ema_avg_pkg::RST_SAMPLE_INTERVAL;
            r_report_interval <= ema_avg_pkg::RST_REPORT_INTERVAL;
            r_gain            <= ema_avg_pkg::RST_SMOOTHING_GAIN;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                ema_avg_pkg::REG_SAMPLE_INTERVAL: r_sample_interval <= pwdata[15:0];
                ema_avg_pkg::REG_REPORT_INTERVAL: r_report_interval <= pwdata[15:0];
                ema_avg_pkg::REG_SMOOTHING_GAIN:  r_gain            <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    ema_avg_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_data         (i_in_data),
        .i_sample_interval (r_sample_interval),
        .i_report_interval (r_report_interval),
        .i_q_full          (w_q_full),
        .o_push            (w_push),
        .o_cmd             (w_front_cmd)
    );

    ema_avg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    ema_avg_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_q_empty   (w_q_empty),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A transfer into the block always leaves work in the queue.
    `EMA_ASSERT_NEXT(a_push_lands, w_push, !w_q_empty, "accepted item missing from queue")

    // The queue is never popped while empty nor pushed while full.
    `EMA_ASSERT_NOW(a_queue_bounds, w_pop || w_push, !(w_pop && w_q_empty) && !(w_push && w_q_full), "queue overrun or underrun")

    // Without a report the average field reads zero.
    `EMA_ASSERT_NOW(a_avg_zero, o_out_valid && !o_out_data.report_valid, o_out_data.report_average == '0, "report average nonzero without report")

endmodule

`default_nettype wire

[rtl/ema_avg_front.sv]
// Front end: accepts input items, checks the sample and report intervals.
// Depends on ema_avg_pkg; feeds ema_avg_queue.
`default_nettype none

module ema_avg_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire ema_avg_pkg::t_in_item         i_in_data,
    input  wire logic [ema_avg_pkg::CFG_W-1:0] i_sample_interval,
    input  wire logic [ema_avg_pkg::CFG_W-1:0] i_report_interval,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output ema_avg_pkg::t_cmd                  o_cmd
);

    logic [ema_avg_pkg::TIME_W-1:0] r_last_sample;
    logic [ema_avg_pkg::TIME_W-1:0] r_last_report;
    logic [ema_avg_pkg::TIME_W-1:0] w_since_sample;
    logic [ema_avg_pkg::TIME_W-1:0] w_since_report;
    logic                           w_take;
    logic                           w_report;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Elapsed times wrap modulo 2^32, so a plain subtraction is enough.
    assign w_since_sample = i_in_data.now_ms - r_last_sample;
    assign w_since_report = i_in_data.now_ms - r_last_report;
    assign w_take   = w_since_sample >= {16'd0, i_sample_interval};
    assign w_report = w_since_report >= {16'd0, i_report_interval};

    assign o_cmd.temperature = i_in_data.temperature;
    assign o_cmd.take_sample = w_take;
    assign o_cmd.do_report   = w_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
            r_last_report <= '0;
        end else if (o_push) begin
            if (w_take) begin
                r_last_sample <= i_in_data.now_ms;
            end
            if (w_report) begin
                r_last_report <= i_in_data.now_ms;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ema_avg_queue.sv]
// Two-entry queue of classified items between the front and the back.
// Depends on ema_avg_pkg.
`default_nettype none

module ema_avg_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ema_avg_pkg::t_cmd i_cmd,
    input  wire logic              i_pop,
    output ema_avg_pkg::t_cmd      o_cmd,
    output logic                   o_full,
    output logic                   o_empty
);

    ema_avg_pkg::t_cmd r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ema_avg_back.sv]
// Back end: filter update, sample accumulation, serial mean division, output register.
// Depends on ema_avg_pkg; takes work from ema_avg_queue.
`default_nettype none

module ema_avg_back #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ema_avg_pkg::CFG_W-1:0] i_gain,
    input  wire logic                          i_q_empty,
    input  wire ema_avg_pkg::t_cmd             i_cmd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ema_avg_pkg::t_out_item             o_out_data
);

    localparam int TW     = ema_avg_pkg::TEMP_W;
    localparam int SUM_W  = TW + COUNT_BITS;
    localparam int ITER_W = $clog2(SUM_W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_REP  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIX  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]                r_state;
    ema_avg_pkg::t_cmd         r_cmd;
    logic signed [TW-1:0]      r_filter;
    logic                      r_primed;
    logic signed [SUM_W-1:0]   r_sum;
    logic [COUNT_BITS-1:0]     r_count;
    logic signed [40:0]        r_p1;
    logic signed [41:0]        r_p2;
    logic [COUNT_BITS:0]       r_rem;
    logic [SUM_W-1:0]          r_quo;
    logic [ITER_W-1:0]         r_div_cnt;
    logic                      r_neg;
    logic                      r_rep_valid;
    logic signed [TW-1:0]      r_avg;
    logic                      r_out_valid;
    ema_avg_pkg::t_out_item    r_out;

    logic signed [16:0]        w_gain_s;
    logic signed [17:0]        w_comp_s;
    logic signed [40:0]        w_p1;
    logic signed [41:0]        w_p2;
    logic signed [42:0]        w_acc;
    logic [SUM_W-1:0]          w_sum_mag;
    logic [COUNT_BITS:0]       w_rem_sh;
    logic                      w_ge;
    logic [SUM_W-1:0]          w_quo_signed;
    logic                      w_out_free;

    assign w_gain_s = {1'b0, i_gain};
    // 65536 - gain, kept as a positive signed factor.
    assign w_comp_s = {1'b0, 17'h10000 - {1'b0, i_gain}};
    assign w_p1     = w_gain_s * r_cmd.temperature;
    assign w_p2     = w_comp_s * r_filter;
    assign w_acc    = {{2{r_p1[40]}}, r_p1} + {r_p2[41], r_p2} + 43'sd32768;

    assign w_sum_mag    = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_rem_sh     = {r_rem[COUNT_BITS-1:0], r_quo[SUM_W-1]};
    assign w_ge         = w_rem_sh >= {1'b0, r_count};
    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_MUL1) begin
            r_p1 <= w_p1;
        end
        if (r_state == S_MUL2) begin
            r_p2 <= w_p2;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.filtered_temp  <= r_filter;
            r_out.sample_taken   <= r_cmd.take_sample;
            r_out.report_valid   <= r_rep_valid;
            r_out.report_average <= r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filter    <= '0;
            r_primed    <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_rem       <= '0;
            r_quo       <= '0;
            r_div_cnt   <= '0;
            r_neg       <= 1'b0;
            r_rep_valid <= 1'b0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loaded in the same cycle keeps the output valid.
            if (r_out_valid && i_out_ready && !(r_state == S_OUT && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= i_cmd.take_sample ? S_MUL1 : S_REP;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // The first sample seeds the filter directly.
                    r_filter <= r_primed ? w_acc[39:16] : r_cmd.temperature;
                    r_primed <= 1'b1;
                    r_state  <= S_ACC;
                end
                S_ACC: begin
                    if (r_count != {COUNT_BITS{1'b1}}) begin
                        r_sum   <= r_sum + {{(SUM_W-TW){r_filter[TW-1]}}, r_filter};
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_REP;
                end
                S_REP: begin
                    r_rep_valid <= 1'b0;
                    r_avg       <= '0;
                    if (r_cmd.do_report && r_count != '0) begin
                        r_quo     <= w_sum_mag;
                        r_neg     <= r_sum[SUM_W-1];
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    // One restoring division step per cycle, quotient bits shift in.
                    r_rem   <= w_ge ? (w_rem_sh - {1'b0, r_count}) : w_rem_sh;
                    r_quo   <= {r_quo[SUM_W-2:0], w_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == ITER_W'(SUM_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_avg       <= w_quo_signed[TW-1:0];
                    r_rep_valid <= 1'b1;
                    r_sum       <= '0;
                    r_count     <= '0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
